// File: hw/rtl/mos6502_alu_register_flags_unit_macros.svh
// assertion macros for the 6502 execute unit
// no dependencies; included by the modules that carry checks
`ifndef MOS6502_ALU_REGISTER_FLAGS_UNIT_MACROS_SVH
`define MOS6502_ALU_REGISTER_FLAGS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define M65_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define M65_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define M65_ASSERT_IMP(name, clk, rstn, ante, cons)
`define M65_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/m65alu_pkg.sv
// types, operation codes and flag positions for the 6502 execute unit
// no dependencies; used by every module of the unit
package m65alu_pkg;

    typedef enum logic [5:0] {
        ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
        ACT_EOR = 6'd4,  ACT_BIT = 6'd5,  ACT_CMP = 6'd6,  ACT_CPX = 6'd7,
        ACT_CPY = 6'd8,  ACT_ASL = 6'd9,  ACT_LSR = 6'd10, ACT_ROL = 6'd11,
        ACT_ROR = 6'd12, ACT_INC = 6'd13, ACT_DEC = 6'd14, ACT_INX = 6'd15,
        ACT_INY = 6'd16, ACT_DEX = 6'd17, ACT_DEY = 6'd18, ACT_LDA = 6'd19,
        ACT_LDX = 6'd20, ACT_LDY = 6'd21, ACT_STA = 6'd22, ACT_STX = 6'd23,
        ACT_STY = 6'd24, ACT_TAX = 6'd25, ACT_TAY = 6'd26, ACT_TSX = 6'd27,
        ACT_TXA = 6'd28, ACT_TXS = 6'd29, ACT_TYA = 6'd30, ACT_CLC = 6'd31,
        ACT_SEC = 6'd32, ACT_CLD = 6'd33, ACT_SED = 6'd34, ACT_CLI = 6'd35,
        ACT_SEI = 6'd36, ACT_CLV = 6'd37, ACT_BCC = 6'd38, ACT_BCS = 6'd39,
        ACT_BEQ = 6'd40, ACT_BNE = 6'd41, ACT_BMI = 6'd42, ACT_BPL = 6'd43,
        ACT_BVC = 6'd44, ACT_BVS = 6'd45, ACT_PHA = 6'd46, ACT_PHP = 6'd47,
        ACT_PLA = 6'd48, ACT_PLP = 6'd49, ACT_RTI = 6'd50, ACT_NMI = 6'd51,
        ACT_IRQ = 6'd52, ACT_RESET = 6'd53
    } act_t;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        act_t       act;
        logic [7:0] operand;
        logic       on_acc;
    } item_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } arch_state_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       write_back;
        logic       taken;
    } exec_result_t;

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r         = p;
        r[FLAG_Z] = (v == 8'h00);
        r[FLAG_N] = v[7];
        return r;
    endfunction

endpackage

// File: hw/rtl/mos6502_alu_register_flags_unit.sv
// channel   direction  payload
// s_        in         s_action, s_operand, s_on_accumulator
// m_        out        m_result_byte, m_write_back, m_taken, m_status, m_acc_out,
//                      m_x_out, m_y_out, m_stack_ptr_out
//
// one operation per cycle sustained while m_ready holds; an s_ transfer reaches m_valid through
// the input register, then execute into the register file and the result register
// the pace is set by the combinational execute path from the register file back to itself
// reset: A, X, Y, S cleared, P = 0x24, both channels empty
// a stalled m_ holds the result; one more item waits in the input register,
// after which s_ready drops
// top level of the 6502 execute unit; depends on m65alu_pkg, m65alu_exec, m65alu_regs and the macros header
`include "mos6502_alu_register_flags_unit_macros.svh"
module mos6502_alu_register_flags_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [5:0] s_action,
    input  logic [7:0] s_operand,
    input  logic       s_on_accumulator,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_byte,
    output logic       m_write_back,
    output logic       m_taken,
    output logic [7:0] m_status,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_x_out,
    output logic [7:0] m_y_out,
    output logic [7:0] m_stack_ptr_out
);

    m65alu_pkg::item_t        item_reg;
    logic                     item_valid_reg;
    m65alu_pkg::arch_state_t  state;
    m65alu_pkg::arch_state_t  state_next;
    m65alu_pkg::exec_result_t res_next;
    m65alu_pkg::exec_result_t res_reg;
    m65alu_pkg::arch_state_t  snap_reg;
    logic                     out_valid_reg;
    logic                     issue;

    assign issue   = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || issue;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.act     <= m65alu_pkg::act_t'(s_action);
            item_reg.operand <= s_operand;
            item_reg.on_acc  <= s_on_accumulator;
        end
    end

    m65alu_exec u_exec (
        .item (item_reg),
        .cur  (state),
        .nxt  (state_next),
        .res  (res_next)
    );

    m65alu_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (issue),
        .state_next (state_next),
        .state      (state)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (issue) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            res_reg  <= res_next;
            snap_reg <= state_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_byte   = res_reg.result_byte;
    assign m_write_back    = res_reg.write_back;
    assign m_taken         = res_reg.taken;
    assign m_status        = snap_reg.p;
    assign m_acc_out       = snap_reg.a;
    assign m_x_out         = snap_reg.x;
    assign m_y_out         = snap_reg.y;
    assign m_stack_ptr_out = snap_reg.s;

    // u always set and b never set in the held status
    `M65_ASSERT_IMP(a_status_u_set, aclk, aresetn, 1'b1, state.p[m65alu_pkg::FLAG_U])
    `M65_ASSERT_IMP(a_status_b_clear, aclk, aresetn, 1'b1, !state.p[m65alu_pkg::FLAG_B])
    `M65_ASSERT_IMP(a_byte_zero_no_wb, aclk, aresetn, m_valid && !m_write_back, m_result_byte == 8'h00)
    `M65_ASSERT_NEXT(a_item_kept, aclk, aresetn, item_valid_reg && !issue, item_valid_reg)
    `M65_ASSERT_NEXT(a_issue_gives_result, aclk, aresetn, issue, m_valid)

endmodule

// File: hw/rtl/m65alu_exec.sv
// combinational execute logic: one operation against the register state
// depends on m65alu_pkg
module m65alu_exec (
    input  m65alu_pkg::item_t        item,
    input  m65alu_pkg::arch_state_t  cur,
    output m65alu_pkg::arch_state_t  nxt,
    output m65alu_pkg::exec_result_t res
);

    logic [7:0] add_m;
    logic [8:0] sum;
    logic [7:0] cmp_r;
    logic [8:0] diff;
    logic [7:0] src;
    logic [7:0] shifted;
    logic       shift_c;
    logic [7:0] irq_push;

    // adder shared by ADC and SBC
    assign add_m = (item.act == m65alu_pkg::ACT_SBC) ? ~item.operand : item.operand;
    assign sum   = {1'b0, cur.a} + {1'b0, add_m} + {8'd0, cur.p[m65alu_pkg::FLAG_C]};

    // compare subtractor
    always_comb begin
        case (item.act)
            m65alu_pkg::ACT_CPX: cmp_r = cur.x;
            m65alu_pkg::ACT_CPY: cmp_r = cur.y;
            default:             cmp_r = cur.a;
        endcase
    end
    assign diff = {1'b0, cmp_r} - {1'b0, item.operand};

    // shifter
    assign src = item.on_acc ? cur.a : item.operand;
    always_comb begin
        case (item.act)
            m65alu_pkg::ACT_ASL: begin
                shifted = {src[6:0], 1'b0};
                shift_c = src[7];
            end
            m65alu_pkg::ACT_LSR: begin
                shifted = {1'b0, src[7:1]};
                shift_c = src[0];
            end
            m65alu_pkg::ACT_ROL: begin
                shifted = {src[6:0], cur.p[m65alu_pkg::FLAG_C]};
                shift_c = src[7];
            end
            default: begin
                shifted = {cur.p[m65alu_pkg::FLAG_C], src[7:1]};
                shift_c = src[0];
            end
        endcase
    end

    assign irq_push = (cur.p & ~(8'h01 << m65alu_pkg::FLAG_B)) | (8'h01 << m65alu_pkg::FLAG_U);

    always_comb begin
        nxt = cur;
        res = '0;
        unique case (item.act)
            m65alu_pkg::ACT_ADC, m65alu_pkg::ACT_SBC: begin
                nxt.a = sum[7:0];
                nxt.p = m65alu_pkg::with_nz(cur.p, sum[7:0]);
                nxt.p[m65alu_pkg::FLAG_C] = sum[8];
                nxt.p[m65alu_pkg::FLAG_V] = ~(cur.a[7] ^ add_m[7]) & (cur.a[7] ^ sum[7]);
            end
            m65alu_pkg::ACT_AND: begin
                nxt.a = cur.a & item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.a & item.operand);
            end
            m65alu_pkg::ACT_ORA: begin
                nxt.a = cur.a | item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.a | item.operand);
            end
            m65alu_pkg::ACT_EOR: begin
                nxt.a = cur.a ^ item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.a ^ item.operand);
            end
            m65alu_pkg::ACT_BIT: begin
                nxt.p[m65alu_pkg::FLAG_Z] = ((cur.a & item.operand) == 8'h00);
                nxt.p[m65alu_pkg::FLAG_N] = item.operand[7];
                nxt.p[m65alu_pkg::FLAG_V] = item.operand[6];
            end
            m65alu_pkg::ACT_CMP, m65alu_pkg::ACT_CPX, m65alu_pkg::ACT_CPY: begin
                nxt.p[m65alu_pkg::FLAG_Z] = (cmp_r == item.operand);
                nxt.p[m65alu_pkg::FLAG_N] = diff[7];
                nxt.p[m65alu_pkg::FLAG_C] = ~diff[8];
            end
            m65alu_pkg::ACT_ASL, m65alu_pkg::ACT_LSR,
            m65alu_pkg::ACT_ROL, m65alu_pkg::ACT_ROR: begin
                nxt.p = m65alu_pkg::with_nz(cur.p, shifted);
                nxt.p[m65alu_pkg::FLAG_C] = shift_c;
                if (item.on_acc) begin
                    nxt.a = shifted;
                end else begin
                    res.result_byte = shifted;
                    res.write_back  = 1'b1;
                end
            end
            m65alu_pkg::ACT_INC: begin
                res.result_byte = item.operand + 8'd1;
                res.write_back  = 1'b1;
                nxt.p = m65alu_pkg::with_nz(cur.p, item.operand + 8'd1);
            end
            m65alu_pkg::ACT_DEC: begin
                res.result_byte = item.operand - 8'd1;
                res.write_back  = 1'b1;
                nxt.p = m65alu_pkg::with_nz(cur.p, item.operand - 8'd1);
            end
            m65alu_pkg::ACT_INX: begin
                nxt.x = cur.x + 8'd1;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.x + 8'd1);
            end
            m65alu_pkg::ACT_INY: begin
                nxt.y = cur.y + 8'd1;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.y + 8'd1);
            end
            m65alu_pkg::ACT_DEX: begin
                nxt.x = cur.x - 8'd1;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.x - 8'd1);
            end
            m65alu_pkg::ACT_DEY: begin
                nxt.y = cur.y - 8'd1;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.y - 8'd1);
            end
            m65alu_pkg::ACT_LDA, m65alu_pkg::ACT_PLA: begin
                nxt.a = item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, item.operand);
                if (item.act == m65alu_pkg::ACT_PLA) begin
                    nxt.s = cur.s + 8'd1;
                end
            end
            m65alu_pkg::ACT_LDX: begin
                nxt.x = item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, item.operand);
            end
            m65alu_pkg::ACT_LDY: begin
                nxt.y = item.operand;
                nxt.p = m65alu_pkg::with_nz(cur.p, item.operand);
            end
            m65alu_pkg::ACT_STA: begin
                res.result_byte = cur.a;
                res.write_back  = 1'b1;
            end
            m65alu_pkg::ACT_STX: begin
                res.result_byte = cur.x;
                res.write_back  = 1'b1;
            end
            m65alu_pkg::ACT_STY: begin
                res.result_byte = cur.y;
                res.write_back  = 1'b1;
            end
            m65alu_pkg::ACT_TAX: begin
                nxt.x = cur.a;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.a);
            end
            m65alu_pkg::ACT_TAY: begin
                nxt.y = cur.a;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.a);
            end
            m65alu_pkg::ACT_TSX: begin
                nxt.x = cur.s;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.s);
            end
            m65alu_pkg::ACT_TXA: begin
                nxt.a = cur.x;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.x);
            end
            m65alu_pkg::ACT_TXS: nxt.s = cur.x;
            m65alu_pkg::ACT_TYA: begin
                nxt.a = cur.y;
                nxt.p = m65alu_pkg::with_nz(cur.p, cur.y);
            end
            m65alu_pkg::ACT_CLC: nxt.p[m65alu_pkg::FLAG_C] = 1'b0;
            m65alu_pkg::ACT_SEC: nxt.p[m65alu_pkg::FLAG_C] = 1'b1;
            m65alu_pkg::ACT_CLD: nxt.p[m65alu_pkg::FLAG_D] = 1'b0;
            m65alu_pkg::ACT_SED: nxt.p[m65alu_pkg::FLAG_D] = 1'b1;
            m65alu_pkg::ACT_CLI: nxt.p[m65alu_pkg::FLAG_I] = 1'b0;
            m65alu_pkg::ACT_SEI: nxt.p[m65alu_pkg::FLAG_I] = 1'b1;
            m65alu_pkg::ACT_CLV: nxt.p[m65alu_pkg::FLAG_V] = 1'b0;
            m65alu_pkg::ACT_BCC: res.taken = ~cur.p[m65alu_pkg::FLAG_C];
            m65alu_pkg::ACT_BCS: res.taken = cur.p[m65alu_pkg::FLAG_C];
            m65alu_pkg::ACT_BEQ: res.taken = cur.p[m65alu_pkg::FLAG_Z];
            m65alu_pkg::ACT_BNE: res.taken = ~cur.p[m65alu_pkg::FLAG_Z];
            m65alu_pkg::ACT_BMI: res.taken = cur.p[m65alu_pkg::FLAG_N];
            m65alu_pkg::ACT_BPL: res.taken = ~cur.p[m65alu_pkg::FLAG_N];
            m65alu_pkg::ACT_BVC: res.taken = ~cur.p[m65alu_pkg::FLAG_V];
            m65alu_pkg::ACT_BVS: res.taken = cur.p[m65alu_pkg::FLAG_V];
            m65alu_pkg::ACT_PHA: begin
                res.result_byte = cur.a;
                res.write_back  = 1'b1;
                nxt.s = cur.s - 8'd1;
            end
            m65alu_pkg::ACT_PHP: begin
                res.result_byte = cur.p | (8'h01 << m65alu_pkg::FLAG_B)
                                        | (8'h01 << m65alu_pkg::FLAG_U);
                res.write_back  = 1'b1;
                nxt.s = cur.s - 8'd1;
            end
            m65alu_pkg::ACT_PLP, m65alu_pkg::ACT_RTI: begin
                nxt.p = item.operand;
                nxt.p[m65alu_pkg::FLAG_B] = 1'b0;
                nxt.p[m65alu_pkg::FLAG_U] = 1'b1;
                nxt.s = (item.act == m65alu_pkg::ACT_PLP) ? cur.s + 8'd1 : cur.s + 8'd3;
            end
            m65alu_pkg::ACT_NMI, m65alu_pkg::ACT_IRQ: begin
                // masked irq leaves everything alone
                if (item.act == m65alu_pkg::ACT_NMI || !cur.p[m65alu_pkg::FLAG_I]) begin
                    res.taken       = (item.act == m65alu_pkg::ACT_IRQ);
                    res.result_byte = irq_push;
                    res.write_back  = 1'b1;
                    nxt.s = cur.s - 8'd3;
                    nxt.p = irq_push;
                    nxt.p[m65alu_pkg::FLAG_I] = 1'b1;
                end
            end
            m65alu_pkg::ACT_RESET: begin
                nxt.s = cur.s - 8'd3;
                nxt.p[m65alu_pkg::FLAG_I] = 1'b1;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: hw/rtl/m65alu_regs.sv
// architectural registers A, X, Y, S and P
// depends on m65alu_pkg; loaded from the execute logic on each issued operation
module m65alu_regs (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  m65alu_pkg::arch_state_t state_next,
    output m65alu_pkg::arch_state_t state
);

    m65alu_pkg::arch_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: 8'h00,
                           p: m65alu_pkg::STATUS_RESET};
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// File: sim/mos6502_alu_register_flags_unit_chk.sv
`timescale 1ns / 100ps
// checker for the 6502 execute unit: keeps its own A, X, Y, S and P, predicts the
// outcome of every s_ transfer and compares each m_ transfer against the oldest one
// depends on m65alu_pkg
module mos6502_alu_register_flags_unit_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [5:0]  s_action,
    input  logic [7:0]  s_operand,
    input  logic        s_on_accumulator,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_result_byte,
    input  logic        m_write_back,
    input  logic        m_taken,
    input  logic [7:0]  m_status,
    input  logic [7:0]  m_acc_out,
    input  logic [7:0]  m_x_out,
    input  logic [7:0]  m_y_out,
    input  logic [7:0]  m_stack_ptr_out,
    output int unsigned fail_count,
    output int unsigned in_flight,
    output int unsigned results_checked,
    output int unsigned taken_count
);

    typedef struct packed {
        logic [7:0] result_byte;
        logic       write_back;
        logic       taken;
        logic [7:0] status;
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
    } step_out_t;

    logic [7:0] acc_q;
    logic [7:0] x_q;
    logic [7:0] y_q;
    logic [7:0] sp_q;
    logic [7:0] p_q;
    step_out_t  pending_steps[$];
    step_out_t  want;
    step_out_t  got;

    task automatic update_nz(input logic [7:0] v);
        p_q[m65alu_pkg::FLAG_Z] = (v == 8'h00);
        p_q[m65alu_pkg::FLAG_N] = v[7];
    endtask

    task automatic add_with_carry(input logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, p_q[m65alu_pkg::FLAG_C]};
        p_q[m65alu_pkg::FLAG_V] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ sum[7]);
        p_q[m65alu_pkg::FLAG_C] = sum[8];
        acc_q = sum[7:0];
        update_nz(acc_q);
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        p_q[m65alu_pkg::FLAG_Z] = (r == m);
        p_q[m65alu_pkg::FLAG_N] = diff[7];
        p_q[m65alu_pkg::FLAG_C] = (r >= m);
    endtask

    task automatic execute_step(input logic [5:0] action, input logic [7:0] opnd,
                                input logic on_acc, output step_out_t res);
        logic [7:0] src;
        logic [7:0] shifted;
        logic [7:0] pushed;
        logic       old_c;
        res    = '0;
        src    = on_acc ? acc_q : opnd;
        old_c  = p_q[m65alu_pkg::FLAG_C];
        pushed = p_q;
        case (action)
            m65alu_pkg::ACT_ADC: add_with_carry(opnd);
            m65alu_pkg::ACT_SBC: add_with_carry(~opnd);
            m65alu_pkg::ACT_AND: begin acc_q = acc_q & opnd; update_nz(acc_q); end
            m65alu_pkg::ACT_ORA: begin acc_q = acc_q | opnd; update_nz(acc_q); end
            m65alu_pkg::ACT_EOR: begin acc_q = acc_q ^ opnd; update_nz(acc_q); end
            m65alu_pkg::ACT_BIT: begin
                p_q[m65alu_pkg::FLAG_Z] = ((acc_q & opnd) == 8'h00);
                p_q[m65alu_pkg::FLAG_N] = opnd[7];
                p_q[m65alu_pkg::FLAG_V] = opnd[6];
            end
            m65alu_pkg::ACT_CMP: compare_reg(acc_q, opnd);
            m65alu_pkg::ACT_CPX: compare_reg(x_q, opnd);
            m65alu_pkg::ACT_CPY: compare_reg(y_q, opnd);
            m65alu_pkg::ACT_ASL, m65alu_pkg::ACT_LSR,
            m65alu_pkg::ACT_ROL, m65alu_pkg::ACT_ROR: begin
                case (action)
                    m65alu_pkg::ACT_ASL: shifted = {src[6:0], 1'b0};
                    m65alu_pkg::ACT_LSR: shifted = {1'b0, src[7:1]};
                    m65alu_pkg::ACT_ROL: shifted = {src[6:0], old_c};
                    default:             shifted = {old_c, src[7:1]};
                endcase
                p_q[m65alu_pkg::FLAG_C] = (action == m65alu_pkg::ACT_ASL ||
                                           action == m65alu_pkg::ACT_ROL) ? src[7] : src[0];
                update_nz(shifted);
                if (on_acc) begin
                    acc_q = shifted;
                end else begin
                    res.result_byte = shifted;
                    res.write_back  = 1'b1;
                end
            end
            m65alu_pkg::ACT_INC: begin
                res.result_byte = opnd + 8'd1;
                res.write_back  = 1'b1;
                update_nz(res.result_byte);
            end
            m65alu_pkg::ACT_DEC: begin
                res.result_byte = opnd - 8'd1;
                res.write_back  = 1'b1;
                update_nz(res.result_byte);
            end
            m65alu_pkg::ACT_INX: begin x_q = x_q + 8'd1; update_nz(x_q); end
            m65alu_pkg::ACT_INY: begin y_q = y_q + 8'd1; update_nz(y_q); end
            m65alu_pkg::ACT_DEX: begin x_q = x_q - 8'd1; update_nz(x_q); end
            m65alu_pkg::ACT_DEY: begin y_q = y_q - 8'd1; update_nz(y_q); end
            m65alu_pkg::ACT_LDA: begin acc_q = opnd; update_nz(acc_q); end
            m65alu_pkg::ACT_LDX: begin x_q = opnd; update_nz(x_q); end
            m65alu_pkg::ACT_LDY: begin y_q = opnd; update_nz(y_q); end
            m65alu_pkg::ACT_STA: begin res.result_byte = acc_q; res.write_back = 1'b1; end
            m65alu_pkg::ACT_STX: begin res.result_byte = x_q; res.write_back = 1'b1; end
            m65alu_pkg::ACT_STY: begin res.result_byte = y_q; res.write_back = 1'b1; end
            m65alu_pkg::ACT_TAX: begin x_q = acc_q; update_nz(x_q); end
            m65alu_pkg::ACT_TAY: begin y_q = acc_q; update_nz(y_q); end
            m65alu_pkg::ACT_TSX: begin x_q = sp_q; update_nz(x_q); end
            m65alu_pkg::ACT_TXA: begin acc_q = x_q; update_nz(acc_q); end
            m65alu_pkg::ACT_TXS: sp_q = x_q;
            m65alu_pkg::ACT_TYA: begin acc_q = y_q; update_nz(acc_q); end
            m65alu_pkg::ACT_CLC: p_q[m65alu_pkg::FLAG_C] = 1'b0;
            m65alu_pkg::ACT_SEC: p_q[m65alu_pkg::FLAG_C] = 1'b1;
            m65alu_pkg::ACT_CLD: p_q[m65alu_pkg::FLAG_D] = 1'b0;
            m65alu_pkg::ACT_SED: p_q[m65alu_pkg::FLAG_D] = 1'b1;
            m65alu_pkg::ACT_CLI: p_q[m65alu_pkg::FLAG_I] = 1'b0;
            m65alu_pkg::ACT_SEI: p_q[m65alu_pkg::FLAG_I] = 1'b1;
            m65alu_pkg::ACT_CLV: p_q[m65alu_pkg::FLAG_V] = 1'b0;
            m65alu_pkg::ACT_BCC: res.taken = !p_q[m65alu_pkg::FLAG_C];
            m65alu_pkg::ACT_BCS: res.taken = p_q[m65alu_pkg::FLAG_C];
            m65alu_pkg::ACT_BEQ: res.taken = p_q[m65alu_pkg::FLAG_Z];
            m65alu_pkg::ACT_BNE: res.taken = !p_q[m65alu_pkg::FLAG_Z];
            m65alu_pkg::ACT_BMI: res.taken = p_q[m65alu_pkg::FLAG_N];
            m65alu_pkg::ACT_BPL: res.taken = !p_q[m65alu_pkg::FLAG_N];
            m65alu_pkg::ACT_BVC: res.taken = !p_q[m65alu_pkg::FLAG_V];
            m65alu_pkg::ACT_BVS: res.taken = p_q[m65alu_pkg::FLAG_V];
            m65alu_pkg::ACT_PHA: begin
                res.result_byte = acc_q;
                res.write_back  = 1'b1;
                sp_q = sp_q - 8'd1;
            end
            m65alu_pkg::ACT_PHP: begin
                pushed[m65alu_pkg::FLAG_B] = 1'b1;
                pushed[m65alu_pkg::FLAG_U] = 1'b1;
                res.result_byte = pushed;
                res.write_back  = 1'b1;
                sp_q = sp_q - 8'd1;
            end
            m65alu_pkg::ACT_PLA: begin
                sp_q  = sp_q + 8'd1;
                acc_q = opnd;
                update_nz(acc_q);
            end
            m65alu_pkg::ACT_PLP, m65alu_pkg::ACT_RTI: begin
                p_q = opnd;
                p_q[m65alu_pkg::FLAG_B] = 1'b0;
                p_q[m65alu_pkg::FLAG_U] = 1'b1;
                sp_q = sp_q + ((action == m65alu_pkg::ACT_PLP) ? 8'd1 : 8'd3);
            end
            m65alu_pkg::ACT_NMI, m65alu_pkg::ACT_IRQ: begin
                // masked irq leaves everything alone
                if (!(action == m65alu_pkg::ACT_IRQ && p_q[m65alu_pkg::FLAG_I])) begin
                    res.taken = (action == m65alu_pkg::ACT_IRQ);
                    pushed[m65alu_pkg::FLAG_B] = 1'b0;
                    pushed[m65alu_pkg::FLAG_U] = 1'b1;
                    res.result_byte = pushed;
                    res.write_back  = 1'b1;
                    sp_q = sp_q - 8'd3;
                    p_q[m65alu_pkg::FLAG_I] = 1'b1;
                    p_q[m65alu_pkg::FLAG_B] = 1'b0;
                    p_q[m65alu_pkg::FLAG_U] = 1'b1;
                end
            end
            m65alu_pkg::ACT_RESET: begin
                sp_q = sp_q - 8'd3;
                p_q[m65alu_pkg::FLAG_I] = 1'b1;
            end
            default: ;
        endcase
        res.status = p_q;
        res.acc    = acc_q;
        res.x      = x_q;
        res.y      = y_q;
        res.sp     = sp_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %02h, got %02h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            acc_q           = 8'h00;
            x_q             = 8'h00;
            y_q             = 8'h00;
            sp_q            = 8'h00;
            p_q             = m65alu_pkg::STATUS_RESET;
            pending_steps.delete();
            fail_count      = 0;
            results_checked = 0;
            taken_count     = 0;
            in_flight      <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_result_byte, m_write_back, m_taken, m_status, m_acc_out,
                       m_x_out, m_y_out, m_stack_ptr_out};
                if (pending_steps.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end else begin
                    want = pending_steps.pop_front();
                    check_field("result_byte", want.result_byte, got.result_byte);
                    check_field("write_back", {7'd0, want.write_back}, {7'd0, got.write_back});
                    check_field("taken", {7'd0, want.taken}, {7'd0, got.taken});
                    check_field("status", want.status, got.status);
                    check_field("acc_out", want.acc, got.acc);
                    check_field("x_out", want.x, got.x);
                    check_field("y_out", want.y, got.y);
                    check_field("stack_ptr_out", want.sp, got.sp);
                    if (want.taken) begin
                        taken_count++;
                    end
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                execute_step(s_action, s_operand, s_on_accumulator, want);
                pending_steps.push_back(want);
            end
            in_flight <= pending_steps.size();
        end
    end

endmodule

// File: sim/mos6502_alu_register_flags_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the 6502 execute unit: drives directed then random operations
// with random idling on both channels; depends on m65alu_pkg, the unit and its checker
module mos6502_alu_register_flags_unit_tb;

    localparam logic [5:0]  ACT_UNUSED_LAST = 6'h3F;
    localparam int unsigned RANDOM_ITEMS    = 1425;
    localparam int unsigned LONG_HOLD       = 64;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned TIMEOUT_NS      = 5000000;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [5:0] s_action         = 6'd0;
    logic [7:0] s_operand        = 8'h00;
    logic       s_on_accumulator = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_result_byte;
    logic       m_write_back;
    logic       m_taken;
    logic [7:0] m_status;
    logic [7:0] m_acc_out;
    logic [7:0] m_x_out;
    logic [7:0] m_y_out;
    logic [7:0] m_stack_ptr_out;

    int unsigned fail_count;
    int unsigned in_flight;
    int unsigned results_checked;
    int unsigned taken_count;
    int unsigned items_sent;
    int unsigned directed_items;
    int unsigned rx_transfers;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    mos6502_alu_register_flags_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_operand        (s_operand),
        .s_on_accumulator (s_on_accumulator),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_byte    (m_result_byte),
        .m_write_back     (m_write_back),
        .m_taken          (m_taken),
        .m_status         (m_status),
        .m_acc_out        (m_acc_out),
        .m_x_out          (m_x_out),
        .m_y_out          (m_y_out),
        .m_stack_ptr_out  (m_stack_ptr_out)
    );

    mos6502_alu_register_flags_unit_chk u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_operand        (s_operand),
        .s_on_accumulator (s_on_accumulator),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_byte    (m_result_byte),
        .m_write_back     (m_write_back),
        .m_taken          (m_taken),
        .m_status         (m_status),
        .m_acc_out        (m_acc_out),
        .m_x_out          (m_x_out),
        .m_y_out          (m_y_out),
        .m_stack_ptr_out  (m_stack_ptr_out),
        .fail_count       (fail_count),
        .in_flight        (in_flight),
        .results_checked  (results_checked),
        .taken_count      (taken_count)
    );

    // one s_ transfer; the first hundred of every four hundred go back to back
    task automatic send_op(input logic [5:0] action, input logic [7:0] opnd,
                           input logic on_acc);
        int unsigned gap;
        gap = ((items_sent % 400) < 100) ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= action;
        s_operand        <= opnd;
        s_on_accumulator <= on_acc;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return 8'h7F;
                    default: return 8'h80;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: random stalls, calm stretches, and a few long hold-offs to fill the unit
    initial begin
        int unsigned hold;
        rx_transfers = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_transfers == 80 || rx_transfers == 420 || rx_transfers == 1000) begin
                hold = LONG_HOLD;
            end else if ((rx_transfers % 400) >= 150 && (rx_transfers % 400) < 250) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 9);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            rx_transfers++;
        end
    end

    initial begin
        logic [5:0] action;
        items_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // overflow, carry and borrow edges of the adder, then a compare and a bit test
        send_op(m65alu_pkg::ACT_LDA, 8'h7F, 1'b0);
        send_op(m65alu_pkg::ACT_ADC, 8'h01, 1'b0);
        send_op(m65alu_pkg::ACT_ADC, 8'hFF, 1'b1);
        send_op(m65alu_pkg::ACT_SBC, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_LDA, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_SBC, 8'h01, 1'b0);
        send_op(m65alu_pkg::ACT_CMP, 8'h80, 1'b0);
        send_op(m65alu_pkg::ACT_BIT, 8'hC0, 1'b0);
        // shifts on the accumulator and on memory, then memory increment and decrement
        send_op(m65alu_pkg::ACT_ASL, 8'hFF, 1'b1);
        send_op(m65alu_pkg::ACT_ROR, 8'h01, 1'b0);
        send_op(m65alu_pkg::ACT_INC, 8'hFF, 1'b0);
        send_op(m65alu_pkg::ACT_DEC, 8'h00, 1'b0);
        // stack traffic and status pulls
        send_op(m65alu_pkg::ACT_LDX, 8'hFF, 1'b0);
        send_op(m65alu_pkg::ACT_TXS, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_PHP, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_PHA, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_PLP, 8'hFF, 1'b0);
        send_op(m65alu_pkg::ACT_RTI, 8'h00, 1'b0);
        // irq taken twice around a cli, then nmi, the reset sequence, an unused code and a branch
        send_op(m65alu_pkg::ACT_IRQ, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_CLI, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_IRQ, 8'h00, 1'b0);
        send_op(m65alu_pkg::ACT_NMI, 8'hFF, 1'b1);
        send_op(m65alu_pkg::ACT_RESET, 8'h00, 1'b0);
        send_op(ACT_UNUSED_LAST, 8'hFF, 1'b1);
        send_op(m65alu_pkg::ACT_BNE, 8'h55, 1'b0);
        directed_items = items_sent;

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                action = 6'($urandom_range(0, 63));
            end else begin
                action = 6'($urandom_range(0, int'(m65alu_pkg::ACT_RESET)));
            end
            send_op(action, pick_operand(), 1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations sent (%0d directed, the rest random over all codes)",
                 items_sent, directed_items);
        $display("%0d results checked, %0d with a branch or irq taken, long output stalls",
                 results_checked, taken_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", in_flight);
        $display("== FAIL ==");
        $finish;
    end

endmodule
